// File: sv/frwm_pkg.sv
// Package for the frame rate window meter: window sizing, divider widths,
// fixed constants and the command/status structs between controller and datapath.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package frwm_pkg;

    // Number of frame intervals averaged by the window.
    localparam int WINDOW_LEN = 128;

    // Ring index, fill count and running sum widths follow the window length.
    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = 32 + $clog2(WINDOW_LEN);

    // Field widths.
    localparam int INTERVAL_W = 32;
    localparam int TARGET_W   = 10;
    localparam int FPS_W      = 24;

    // Divider width covers the running sum and the Q8 rate numerator.
    localparam int RATE_NUM_W = 38;
    localparam int DIV_W      = (SUM_W > RATE_NUM_W) ? SUM_W : RATE_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    // Nanoseconds per second, and the same scaled by 256 for Q16.8 output.
    localparam logic [DIV_W-1:0] NS_PER_SEC = DIV_W'(64'd1000000000);
    localparam logic [DIV_W-1:0] RATE_NUM   = DIV_W'(64'd256000000000);

    localparam logic [TARGET_W-1:0] RESET_TARGET_FPS = TARGET_W'(60);
    localparam logic [FPS_W-1:0]    FPS_MAX          = {FPS_W{1'b1}};

    // Configuration register indexes.
    localparam logic REG_TARGET_FPS = 1'b0;

    // Which quotient the shared divider is asked for.
    typedef enum logic [1:0] {
        DIV_IDEAL,
        DIV_MEAN,
        DIV_RATE
    } div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     pace;
        logic     update;
        logic     load_mean;
        logic     load_out;
    } frwm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic target_zero;
        logic mean_zero;
    } frwm_stat_t;

endpackage

`default_nettype wire

// File: sv/frame_rate_window_meter_unit.sv
// Frame rate window meter, top level: configuration port, controller and datapath.
// Depends on frwm_pkg, frwm_ctrl and frwm_datapath.
`default_nettype none

// Each request carries one measured frame interval in nanoseconds. When target_fps
// (register 0, byte address 0, reset 60) is nonzero, the interval is raised to at
// least floor(1e9 / target_fps). The paced interval enters a 128-entry window and
// the result gives it back together with the windowed mean rate in unsigned Q16.8,
// saturated to 0xFFFFFF with fps_saturated set when the mean is zero or the rate
// overflows. A single bit-per-cycle divider is used in turn for the ideal period
// (skipped when target_fps is zero), the window mean and the rate (skipped when the
// mean is zero). One request is worked at a time; a new one is accepted while the
// previous result still waits in the output register. No clearing pass is needed
// after reset.
module frame_rate_window_meter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] measured_interval_ns,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      paced_interval_ns,
    output logic [23:0]      average_fps_q8,
    output logic             fps_saturated
);

    frwm_pkg::frwm_cmd_t            cmd;
    frwm_pkg::frwm_stat_t           stat;
    logic                           cfg_we;
    logic [frwm_pkg::TARGET_W-1:0]  target_fps;

    // Configuration port: single register, always ready.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == frwm_pkg::REG_TARGET_FPS);
    assign prdata = (paddr[2] == frwm_pkg::REG_TARGET_FPS) ? 32'(target_fps) : '0;

    frwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    frwm_datapath u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .cfg_we               (cfg_we),
        .cfg_wdata            (pwdata[frwm_pkg::TARGET_W-1:0]),
        .target_fps           (target_fps),
        .measured_interval_ns (measured_interval_ns),
        .paced_interval_ns    (paced_interval_ns),
        .average_fps_q8       (average_fps_q8),
        .fps_saturated        (fps_saturated)
    );

    // A request keeps the block busy for the following cycle.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one still in work");

    // The divider only finishes while a request is being worked.
    a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> !in_ready)
        else $error("divider finished while controller idle");

    // A saturated result always carries the maximum rate code.
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fps_saturated |-> average_fps_q8 == frwm_pkg::FPS_MAX)
        else $error("saturated result without maximum rate");

endmodule

`default_nettype wire

// File: sv/frwm_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
// Depends on frwm_pkg for the operand width and the step counter width.
`default_nettype none

module frwm_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [frwm_pkg::DIV_W-1:0] dividend,
    input  wire logic [frwm_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic [frwm_pkg::DIV_W-1:0]     quotient
);

    localparam int W = frwm_pkg::DIV_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [frwm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [W-1:0]                  dvd_reg;
    logic [W-1:0]                  dvs_reg;
    logic [W-1:0]                  rem_reg;
    logic [W:0]                    shifted;
    logic                          fits;
    logic [W-1:0]                  rem_next;

    // One trial subtraction per cycle on the shifted partial remainder.
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[W-1]};
        fits     = (shifted >= {1'b0, dvs_reg});
        rem_next = fits ? W'(shifted - {1'b0, dvs_reg}) : shifted[W-1:0];
    end

    // Control: step counter and a single-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == frwm_pkg::DIV_CNT_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Operands: the quotient bits shift into the dividend register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// File: sv/frwm_datapath.sv
// Datapath of the frame rate window meter: target register, interval ring,
// running sum, fill count, shared divider and the result registers.
// Depends on frwm_pkg and frwm_div.
`default_nettype none

module frwm_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire frwm_pkg::frwm_cmd_t            cmd,
    output frwm_pkg::frwm_stat_t                stat,
    input  wire logic                           cfg_we,
    input  wire logic [frwm_pkg::TARGET_W-1:0]  cfg_wdata,
    output logic [frwm_pkg::TARGET_W-1:0]       target_fps,
    input  wire logic [frwm_pkg::INTERVAL_W-1:0] measured_interval_ns,
    output logic [frwm_pkg::INTERVAL_W-1:0]     paced_interval_ns,
    output logic [frwm_pkg::FPS_W-1:0]          average_fps_q8,
    output logic                                fps_saturated
);

    localparam int W = frwm_pkg::DIV_W;

    logic [frwm_pkg::TARGET_W-1:0]   target_reg;
    logic [frwm_pkg::INTERVAL_W-1:0] ring_mem [frwm_pkg::WINDOW_LEN];
    logic [frwm_pkg::INTERVAL_W-1:0] rd_reg;
    logic [frwm_pkg::SUM_W-1:0]      sum_reg;
    logic [frwm_pkg::SUM_W-1:0]      sum_next;
    logic [frwm_pkg::IDX_W-1:0]      widx_reg;
    logic [frwm_pkg::IDX_W-1:0]      widx_next;
    logic [frwm_pkg::FILL_W-1:0]     fill_reg;
    logic [frwm_pkg::INTERVAL_W-1:0] paced_reg;
    logic [frwm_pkg::INTERVAL_W-1:0] mean_reg;
    logic [frwm_pkg::INTERVAL_W-1:0] out_paced_reg;
    logic [frwm_pkg::FPS_W-1:0]      fps_reg;
    logic                            sat_reg;
    logic                            window_full;
    logic [frwm_pkg::INTERVAL_W-1:0] old_val;
    logic [frwm_pkg::INTERVAL_W-1:0] ideal;
    logic [W-1:0]                    div_dividend;
    logic [W-1:0]                    div_divisor;
    logic                            div_done;
    logic [W-1:0]                    quotient;

    // Target frame rate register, written over the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= frwm_pkg::RESET_TARGET_FPS;
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_wdata;
        end
    end

    // Slots are written in order, so the replaced slot has been written exactly when
    // the window is full; before that the replaced slot reads as zero.
    assign window_full = (fill_reg == frwm_pkg::FILL_W'(frwm_pkg::WINDOW_LEN));
    assign old_val     = window_full ? rd_reg : '0;
    assign ideal       = quotient[frwm_pkg::INTERVAL_W-1:0];

    always_comb
    begin
        sum_next = sum_reg - frwm_pkg::SUM_W'(old_val) + frwm_pkg::SUM_W'(paced_reg);
        if (widx_reg == frwm_pkg::IDX_W'(frwm_pkg::WINDOW_LEN - 1))
        begin
            widx_next = '0;
        end
        else
        begin
            widx_next = widx_reg + 1'b1;
        end
    end

    // Interval ring: read at request time, written during the update.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rd_reg <= ring_mem[widx_reg];
        end
        if (cmd.update)
        begin
            ring_mem[widx_reg] <= paced_reg;
        end
    end

    // Window bookkeeping: running sum, write index and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            widx_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.update)
        begin
            sum_reg  <= sum_next;
            widx_reg <= widx_next;
            if (!window_full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // Divider operand selection.
    always_comb
    begin
        case (cmd.div_sel)
            frwm_pkg::DIV_IDEAL:
            begin
                div_dividend = frwm_pkg::NS_PER_SEC;
                div_divisor  = W'(target_reg);
            end
            frwm_pkg::DIV_MEAN:
            begin
                div_dividend = W'(sum_reg);
                div_divisor  = W'(fill_reg);
            end
            frwm_pkg::DIV_RATE:
            begin
                div_dividend = frwm_pkg::RATE_NUM;
                div_divisor  = W'(mean_reg);
            end
            default:
            begin
                div_dividend = frwm_pkg::NS_PER_SEC;
                div_divisor  = W'(target_reg);
            end
        endcase
    end

    frwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Request capture, pacing and the window mean.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            paced_reg <= measured_interval_ns;
        end
        else if (cmd.pace && (paced_reg < ideal))
        begin
            paced_reg <= ideal;
        end
        if (cmd.load_mean)
        begin
            mean_reg <= quotient[frwm_pkg::INTERVAL_W-1:0];
        end
    end

    // Result registers, with saturation of the Q16.8 rate.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_paced_reg <= paced_reg;
            if (mean_reg == '0)
            begin
                fps_reg <= frwm_pkg::FPS_MAX;
                sat_reg <= 1'b1;
            end
            else if (quotient[W-1:frwm_pkg::FPS_W] != '0)
            begin
                fps_reg <= frwm_pkg::FPS_MAX;
                sat_reg <= 1'b1;
            end
            else
            begin
                fps_reg <= quotient[frwm_pkg::FPS_W-1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign stat.div_done    = div_done;
    assign stat.target_zero = (target_reg == '0);
    assign stat.mean_zero   = (mean_reg == '0);

    assign target_fps         = target_reg;
    assign paced_interval_ns  = out_paced_reg;
    assign average_fps_q8     = fps_reg;
    assign fps_saturated      = sat_reg;

endmodule

`default_nettype wire

// File: sv/frwm_ctrl.sv
// Controller of the frame rate window meter: sequences pacing, window update
// and the three divisions, and owns the request and result handshakes.
// Depends on frwm_pkg for the command and status structs.
`default_nettype none

module frwm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output frwm_pkg::frwm_cmd_t       cmd,
    input  wire frwm_pkg::frwm_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDEAL,
        ST_UPDATE,
        ST_MEAN_GO,
        ST_MEAN,
        ST_RATE_GO,
        ST_RATE,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state, commands and result valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.div_sel    = frwm_pkg::DIV_IDEAL;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (stat.target_zero)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_IDEAL;
                    end
                end
            end
            ST_IDEAL:
            begin
                if (stat.div_done)
                begin
                    cmd.pace   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = frwm_pkg::DIV_MEAN;
                state_next    = ST_MEAN;
            end
            ST_MEAN:
            begin
                if (stat.div_done)
                begin
                    cmd.load_mean = 1'b1;
                    state_next    = ST_RATE_GO;
                end
            end
            ST_RATE_GO:
            begin
                if (stat.mean_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = frwm_pkg::DIV_RATE;
                    state_next    = ST_RATE;
                end
            end
            ST_RATE:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Wait until the result register is free or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: tb/sv/frame_rate_window_meter_unit_tb.sv
// Testbench for frame_rate_window_meter_unit: drives frame intervals, writes the target rate
// over the APB port, and checks each result against an in-bench windowed frame-rate predictor.
// Depends on frwm_pkg and the frame_rate_window_meter_unit RTL.
`timescale 1ns / 100ps

module frame_rate_window_meter_unit_tb;

    import frwm_pkg::*;

    // Run control.
    localparam int unsigned CYCLE_LIMIT   = 1200000;
    localparam int unsigned DRAIN_CYCLES  = 300;
    localparam int unsigned LONG_HOLD     = 500;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PRINT_CAP     = 20;
    localparam int          UNMAPPED_REG  = 1;

    // Rate arithmetic constants, kept at 64 bits.
    localparam logic [63:0] ONE_SECOND_NS  = 64'd1000000000;
    localparam logic [63:0] RATE_SCALED_NS = 64'd256000000000;

    // One result of the block.
    typedef struct packed {
        logic [INTERVAL_W-1:0] paced;
        logic [FPS_W-1:0]      fps_q8;
        logic                  saturated;
    } frame_rate_t;

    // Block ports.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [INTERVAL_W-1:0] measured_interval_ns = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [INTERVAL_W-1:0] paced_interval_ns;
    logic [FPS_W-1:0]      average_fps_q8;
    logic                  fps_saturated;

    // Predictor state: window ring, running sum, write slot, fill count, target rate.
    logic [INTERVAL_W-1:0] window_ring [WINDOW_LEN];
    logic [SUM_W-1:0]      window_total;
    logic [IDX_W-1:0]      write_slot;
    logic [FILL_W-1:0]     fill_count;
    logic [TARGET_W-1:0]   target_rate;

    // Requests waiting to be sent and results waiting to be seen.
    logic [INTERVAL_W-1:0] pending_intervals [$];
    frame_rate_t           expected_rates [$];

    // Traffic shaping and bookkeeping.
    bit          src_idle_en = 1'b1;
    bit          snk_idle_en = 1'b1;
    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = 60;
    int unsigned cycle_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned saturated_seen = 0;
    int unsigned target_writes = 0;
    int unsigned mismatch_count = 0;
    frame_rate_t seen_want;

    frame_rate_window_meter_unit u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .measured_interval_ns (measured_interval_ns),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .paced_interval_ns    (paced_interval_ns),
        .average_fps_q8       (average_fps_q8),
        .fps_saturated        (fps_saturated)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Pace one interval, push it through the window and work out the Q16.8 average rate.
    function automatic frame_rate_t pace_and_average(input logic [INTERVAL_W-1:0] measured);
        frame_rate_t         r;
        logic [63:0]         ideal;
        logic [63:0]         mean;
        logic [63:0]         rate;
        logic [INTERVAL_W-1:0] paced;
        paced = measured;
        if (target_rate != '0)
        begin
            ideal = ONE_SECOND_NS / 64'(target_rate);
            if (64'(paced) < ideal)
                paced = ideal[INTERVAL_W-1:0];
        end
        window_total = window_total - SUM_W'(window_ring[write_slot]) + SUM_W'(paced);
        window_ring[write_slot] = paced;
        write_slot = (write_slot == IDX_W'(WINDOW_LEN - 1)) ? '0 : write_slot + 1'b1;
        if (fill_count < FILL_W'(WINDOW_LEN))
            fill_count = fill_count + 1'b1;
        mean = 64'(window_total) / 64'(fill_count);
        r.paced = paced;
        r.saturated = 1'b0;
        if (mean == 64'd0)
        begin
            r.fps_q8 = FPS_MAX;
            r.saturated = 1'b1;
        end
        else
        begin
            rate = RATE_SCALED_NS / mean;
            if (rate > 64'(FPS_MAX))
            begin
                r.fps_q8 = FPS_MAX;
                r.saturated = 1'b1;
            end
            else
                r.fps_q8 = rate[FPS_W-1:0];
        end
        return r;
    endfunction

    // Random frame interval; small intervals are needed to reach the saturated rates.
    function automatic logic [INTERVAL_W-1:0] pick_interval(input bit tiny,
                                                           input logic [TARGET_W-1:0] tgt);
        logic [31:0] ideal;
        logic [31:0] v;
        ideal = (tgt != '0) ? 32'(ONE_SECOND_NS / 64'(tgt)) : 32'd16666666;
        if (tiny)
        begin
            case ($urandom_range(0, 9))
                0:       v = 32'd0;
                7:       v = $urandom_range(0, 300);
                8:       v = $urandom;
                9:       v = $urandom_range(15000, 16000);
                default: v = $urandom_range(0, 20000);
            endcase
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       v = $urandom;
                1:       v = 32'd0;
                2:       v = 32'hFFFF_FFFF;
                3:       v = ideal + $urandom_range(0, 4) - 32'd2;
                4, 5:    v = $urandom_range(1000000, 120000000);
                6, 7:    v = ideal + $urandom_range(0, ideal / 8);
                8:       v = $urandom_range(0, ideal);
                default: v = $urandom >> $urandom_range(0, 31);
            endcase
        end
        return v;
    endfunction

    // Print one mismatch line (up to a cap) and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: %s mismatch on result %0d: got 0x%0h, expected 0x%0h",
                     $time, what, results_checked, got, want);
        mismatch_count++;
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic apb_write(input int index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * index);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == int'(REG_TARGET_FPS))
        begin
            target_rate = value[TARGET_W-1:0];
            target_writes++;
        end
    endtask

    // Block is idle once every request is sent and every result has come back.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_intervals.size() != 0 || in_valid || expected_rates.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_target(input logic [31:0] value);
        wait_idle();
        apb_write(int'(REG_TARGET_FPS), value);
    endtask

    // Request driver: predicts on acceptance, then offers the next interval or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            measured_interval_ns <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_rates.push_back(pace_and_average(measured_interval_ns));
                requests_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (src_gap != 0)
                begin
                    in_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end
                else if (pending_intervals.size() != 0 && src_idle_en
                         && $urandom_range(0, 9) == 0)
                begin
                    in_valid <= 1'b0;
                    src_gap <= $urandom_range(0, 15);
                end
                else if (pending_intervals.size() != 0)
                begin
                    in_valid <= 1'b1;
                    measured_interval_ns <= pending_intervals.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts, plus long hold-offs that back the block up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            snk_gap <= 0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (results_checked >= next_hold_at)
        begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD - 1;
            next_hold_at <= (next_hold_at < 1000) ? 1000 : 32'hFFFF_FFFF;
        end
        else if (snk_gap != 0)
        begin
            out_ready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end
        else if (snk_idle_en && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            snk_gap <= $urandom_range(0, 15);
        end
        else
            out_ready <= 1'b1;
    end

    // Result monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rates.size() == 0)
                report_mismatch("unexpected result", paced_interval_ns, 32'd0);
            else
            begin
                seen_want = expected_rates.pop_front();
                if (paced_interval_ns !== seen_want.paced)
                    report_mismatch("paced_interval_ns", paced_interval_ns, seen_want.paced);
                if (average_fps_q8 !== seen_want.fps_q8)
                    report_mismatch("average_fps_q8", 32'(average_fps_q8),
                                    32'(seen_want.fps_q8));
                if (fps_saturated !== seen_want.saturated)
                    report_mismatch("fps_saturated", 32'(fps_saturated),
                                    32'(seen_want.saturated));
            end
            if (fps_saturated)
                saturated_seen++;
            results_checked++;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_rates.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        bit                  tiny;
        logic [TARGET_W-1:0] tgt;
        int unsigned         count;

        for (int i = 0; i < WINDOW_LEN; i++)
            window_ring[i] = '0;
        window_total = '0;
        write_slot = '0;
        fill_count = '0;
        target_rate = RESET_TARGET_FPS;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // No limit, junk in the upper register bits: zero mean, then rates too large.
        set_target(32'hFFFF_FC00);
        pending_intervals.push_back(32'd0);
        pending_intervals.push_back(32'd0);
        pending_intervals.push_back(32'd0);
        pending_intervals.push_back(32'd1);
        pending_intervals.push_back(32'd100);
        pending_intervals.push_back(32'd15258);
        pending_intervals.push_back(32'd15259);
        pending_intervals.push_back(32'hFFFF_FFFF);
        pending_intervals.push_back(32'hFFFF_FFFF);

        // A write outside the register map must leave the target alone.
        wait_idle();
        apb_write(UNMAPPED_REG, 32'd5);
        pending_intervals.push_back(32'd0);

        // Target above the nominal range.
        set_target(32'd1023);
        pending_intervals.push_back(32'd0);
        pending_intervals.push_back(32'd977516);
        pending_intervals.push_back(32'd977517);
        pending_intervals.push_back(32'd977518);
        pending_intervals.push_back(32'hFFFF_FFFF);

        // Slowest target: one frame per second.
        set_target(32'd1);
        pending_intervals.push_back(32'd0);
        pending_intervals.push_back(32'd999999999);
        pending_intervals.push_back(32'd1000000000);
        pending_intervals.push_back(32'd1000000001);

        set_target(32'd1000);
        pending_intervals.push_back(32'd999999);
        pending_intervals.push_back(32'd1000000);
        pending_intervals.push_back(32'd1000001);

        set_target(32'(RESET_TARGET_FPS));
        pending_intervals.push_back(32'd16666666);
        pending_intervals.push_back(32'd16666667);

        // Random phases, each with its own target; the last one runs without idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            tiny = (ph == 0 || ph == 5);
            case ($urandom_range(0, 6))
                0:       tgt = '0;
                1:       tgt = 10'd1;
                2:       tgt = 10'd1000;
                3:       tgt = 10'd1023;
                4:       tgt = RESET_TARGET_FPS;
                default: tgt = TARGET_W'($urandom);
            endcase
            if (tiny)
                tgt = '0;
            set_target(($urandom & 32'hFFFF_FC00) | 32'(tgt));
            if (ph == RANDOM_PHASES - 1)
            begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end
            else
            begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                snk_idle_en = ($urandom_range(0, 3) != 0);
            end
            count = $urandom_range(130, 180);
            repeat (count)
                pending_intervals.push_back(pick_interval(tiny, tgt));
        end

        // Drain, then allow time for any stray result to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d frame intervals under %0d target rate settings.",
                 requests_sent, target_writes);
        $display("%0d results checked, %0d with saturated rate, %0d mismatches.",
                 results_checked, saturated_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
